[hw/rtl/lss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

   localparam int LEN_BITS    = 13;
   localparam int CNT_BITS    = 16;
   localparam int RESULT_BITS = 20;
   localparam int CSR_BITS    = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam int LINE_LENGTH_RESET = 4096;
   localparam logic [CNT_BITS-1:0] LINE_COUNT_RESET = 16'd1024;
   localparam int MIN_LINE_LENGTH = 3;
   localparam logic [CNT_BITS-1:0] MIN_LINE_COUNT = 16'd3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LINE_LENGTH = 1'b0,
      CSR_LINE_COUNT  = 1'b1
   } lss_csr_type;

   // per-item control that travels from the sequencer into the compute stage
   typedef struct packed {
      logic flush;   // last line drains from the middle store
      logic emit;    // item produces a result
      logic border;  // result is 2p
      logic last;    // final result of the frame
   } lss_op_type;

endpackage

`default_nettype wire

[hw/rtl/lss_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lss_req_if #(
   parameter int PIXEL_BITS = 16
) ();
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [PIXEL_BITS-1:0] pixel;

   modport source (output valid, output kind, output pixel, input ready);
   modport sink   (input valid, input kind, input pixel, output ready);
endinterface

`default_nettype wire

[hw/rtl/lss_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lss_rsp_if import lss_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [RESULT_BITS-1:0] sharpened_times_two;
   logic                          last_of_frame;

   modport source (output valid, output sharpened_times_two, output last_of_frame,
                   input ready);
   modport sink   (input valid, input sharpened_times_two, input last_of_frame,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/lss_csr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lss_csr_if import lss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/laplacian_sharpen_stream.sv]
`timescale 1ns / 1ps
`default_nettype none

// The result caused by an accepted item passes the compute stage and the output register
// and is offered on rsp; a pixel's own result leaves with the pixel one line below it, or
// with a drain item. Throughput: one item per cycle unless a stalled rsp blocks the stage;
// the line stores are read at acceptance and written as the item leaves the compute stage,
// so no two accesses in flight hit the same entry.
// Reset: counters clear, line_length = 4096 (capped at MAX_LINE), line_count = 1024;
// the line stores are not cleared and need no clearing pass.
module laplacian_sharpen_stream import lss_pkg::*; #(
   parameter int MAX_LINE   = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   lss_req_if.sink   req_bus,
   lss_rsp_if.source rsp_bus,
   lss_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(MAX_LINE);

   logic                  accept;
   logic                  load;
   lss_op_type            op;
   logic [AW-1:0]         pos;
   logic [AW-1:0]         right_addr;
   logic                  stage_free;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [PIXEL_BITS-1:0] wr_older;
   logic [PIXEL_BITS-1:0] wr_middle;
   logic [PIXEL_BITS-1:0] up;
   logic [PIXEL_BITS-1:0] centre;
   logic [PIXEL_BITS-1:0] right;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = stage_free;
   assign accept        = req_bus.valid && stage_free;

   lss_seq #(
      .MAX_LINE (MAX_LINE)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_bus.valid),
      .csr_index  (csr_bus.index),
      .csr_data   (csr_bus.data),
      .accept     (accept),
      .kind       (req_bus.kind),
      .load       (load),
      .op         (op),
      .pos        (pos),
      .right_addr (right_addr)
   );

   lss_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_LINE)
   ) u_older (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_older),
      .rd_en   (load),
      .rd_addr (pos),
      .rd_data (up)
   );

   // the middle line is kept twice so centre and right read in the same cycle
   lss_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_LINE)
   ) u_middle_c (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_middle),
      .rd_en   (load),
      .rd_addr (pos),
      .rd_data (centre)
   );

   lss_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_LINE)
   ) u_middle_r (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_middle),
      .rd_en   (load),
      .rd_addr (right_addr),
      .rd_data (right)
   );

   lss_calc #(
      .MAX_LINE   (MAX_LINE),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_calc (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .op         (op),
      .pos        (pos),
      .pixel      (req_bus.pixel),
      .up         (up),
      .centre     (centre),
      .right      (right),
      .stage_free (stage_free),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_older   (wr_older),
      .wr_middle  (wr_middle),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_value  (rsp_bus.sharpened_times_two),
      .rsp_last   (rsp_bus.last_of_frame)
   );

endmodule

`default_nettype wire

[hw/rtl/lss_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module lss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lss_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module lss_seq import lss_pkg::*; #(
   parameter int MAX_LINE = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [CSR_BITS-1:0]         csr_data,
   input  wire logic                        accept,
   input  wire logic                        kind,
   output logic                             load,
   output lss_op_type                       op,
   output logic      [$clog2(MAX_LINE)-1:0] pos,
   output logic      [$clog2(MAX_LINE)-1:0] right_addr
);

   localparam int AW = $clog2(MAX_LINE);
   localparam int RESET_LEN = (MAX_LINE < LINE_LENGTH_RESET) ? MAX_LINE : LINE_LENGTH_RESET;

   logic [AW-1:0]       len_last_ff, len_last_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [CNT_BITS-1:0] line_ff, line_in;

   logic                flushing;
   logic                at_end;
   logic [31:0]         len_req;
   logic [31:0]         len_clamped;

   assign flushing = (line_ff >= cnt_ff);
   assign at_end   = (pos_ff == len_last_ff);

   assign op.flush  = flushing;
   assign op.emit   = flushing || (line_ff != '0);
   assign op.border = flushing || (line_ff == CNT_BITS'(1)) || (pos_ff == '0) || at_end;
   assign op.last   = flushing && at_end;

   assign load       = accept && (flushing || !kind);
   assign pos        = pos_ff;
   assign right_addr = at_end ? '0 : pos_ff + AW'(1);

   always_comb begin
      len_req = 32'(csr_data[LEN_BITS-1:0]);
      priority if (len_req < 32'(MIN_LINE_LENGTH)) begin
         len_clamped = 32'(MIN_LINE_LENGTH);
      end else if (len_req > 32'(MAX_LINE)) begin
         len_clamped = 32'(MAX_LINE);
      end else begin
         len_clamped = len_req;
      end
   end

   always_comb begin
      len_last_in = len_last_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      line_in     = line_ff;
      if (csr_valid) begin
         // any register write restarts the frame
         pos_in  = '0;
         line_in = '0;
         unique case (lss_csr_type'(csr_index))
            CSR_LINE_LENGTH: len_last_in = AW'(len_clamped - 32'd1);
            CSR_LINE_COUNT: begin
               cnt_in = (csr_data[CNT_BITS-1:0] < MIN_LINE_COUNT) ? MIN_LINE_COUNT
                                                                  : csr_data[CNT_BITS-1:0];
            end
         endcase
      end else if (accept && (flushing || !kind)) begin
         pos_in = at_end ? '0 : pos_ff + AW'(1);
         if (at_end) begin
            line_in = flushing ? '0 : line_ff + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_last_ff <= AW'(RESET_LEN - 1);
         cnt_ff      <= LINE_COUNT_RESET;
         pos_ff      <= '0;
         line_ff     <= '0;
      end else begin
         len_last_ff <= len_last_in;
         cnt_ff      <= cnt_in;
         pos_ff      <= pos_in;
         line_ff     <= line_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lss_calc.sv]
`timescale 1ns / 1ps
`default_nettype none

module lss_calc import lss_pkg::*; #(
   parameter int MAX_LINE   = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire lss_op_type                    op,
   input  wire logic [$clog2(MAX_LINE)-1:0]   pos,
   input  wire logic [PIXEL_BITS-1:0]         pixel,
   input  wire logic [PIXEL_BITS-1:0]         up,
   input  wire logic [PIXEL_BITS-1:0]         centre,
   input  wire logic [PIXEL_BITS-1:0]         right,
   output logic                               stage_free,
   output logic                               wr_en,
   output logic      [$clog2(MAX_LINE)-1:0]   wr_addr,
   output logic      [PIXEL_BITS-1:0]         wr_older,
   output logic      [PIXEL_BITS-1:0]         wr_middle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [RESULT_BITS-1:0]      rsp_value,
   output logic                               rsp_last
);

   localparam int AW = $clog2(MAX_LINE);
   localparam int CALC_W = (PIXEL_BITS + 4 > RESULT_BITS) ? PIXEL_BITS + 4 : RESULT_BITS;

   logic                          s1_valid_ff, s1_valid_in;
   lss_op_type                    s1_op_ff;
   logic [AW-1:0]                 s1_pos_ff;
   logic [PIXEL_BITS-1:0]         s1_pix_ff;
   logic [PIXEL_BITS-1:0]         left_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_BITS-1:0] rsp_value_ff;
   logic                          rsp_last_ff;

   logic                          out_free;
   logic                          s1_adv;
   logic signed [CALC_W-1:0]      c_ext;
   logic signed [CALC_W-1:0]      six_c;
   logic signed [CALC_W-1:0]      sum;
   logic signed [CALC_W-1:0]      result;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_adv     = s1_valid_ff && (!s1_op_ff.emit || out_free);
   assign stage_free = !s1_valid_ff || s1_adv;

   // write back on the way out of the stage; drained items leave the stores alone
   assign wr_en     = s1_adv && !s1_op_ff.flush;
   assign wr_addr   = s1_pos_ff;
   assign wr_older  = centre;
   assign wr_middle = s1_pix_ff;

   always_comb begin
      c_ext  = CALC_W'(centre);
      six_c  = (c_ext <<< 2) + (c_ext <<< 1);
      sum    = CALC_W'(up) + CALC_W'(s1_pix_ff) + CALC_W'(left_ff) + CALC_W'(right);
      result = s1_op_ff.border ? (c_ext <<< 1) : (six_c - sum);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_op_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_op_ff  <= op;
         s1_pos_ff <= pos;
         s1_pix_ff <= pixel;
      end
      if (wr_en) begin
         left_ff <= centre;
      end
      if (s1_adv && s1_op_ff.emit) begin
         rsp_value_ff <= result[RESULT_BITS-1:0];
         rsp_last_ff  <= s1_op_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      load |-> stage_free) else $error("item loaded into occupied stage");

   a_load_occupies: assert property (@(posedge clock) disable iff (reset)
      load |=> s1_valid_ff) else $error("loaded item lost");

   a_emit_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_op_ff.emit && rsp_valid_ff && !rsp_ready |-> !wr_en && !stage_free)
      else $error("result stage advanced into a full output register");

   a_last_only_on_flush: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_op_ff.last |-> s1_op_ff.flush && !wr_en)
      else $error("frame end outside the drain phase");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import lss_pkg::*;

   localparam int   MAX_LINE    = 4096;
   localparam int   PIXEL_BITS  = 16;
   localparam int   QUIET_LIMIT = 4000;
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_DRAIN  = 1'b1;

   typedef struct {
      logic signed [RESULT_BITS-1:0] value;
      logic                          last;
   } sharp_result_type;

   logic clock = 1'b0;
   logic reset;

   lss_req_if #(.PIXEL_BITS(PIXEL_BITS)) req_bus ();
   lss_rsp_if rsp_bus ();
   lss_csr_if csr_bus ();

   laplacian_sharpen_stream #(.MAX_LINE(MAX_LINE), .PIXEL_BITS(PIXEL_BITS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   // shadow of the block: two line stores, window position, registers
   logic [15:0]         older_line  [MAX_LINE];
   logic [15:0]         middle_line [MAX_LINE];
   int unsigned         col_m;
   logic [15:0]         row_m;
   int                  left_m;
   logic [LEN_BITS-1:0] line_length_m;
   logic [CNT_BITS-1:0] line_count_m;
   sharp_result_type    sharpened_q [$];

   int errors       = 0;
   int quiet_cycles = 0;
   bit gaps_on      = 1'b0;
   bit stalls_on    = 1'b0;
   int rsp_hold_len = 0;

   function automatic int unsigned clamp_len(input logic [LEN_BITS-1:0] l);
      if (l < 3) return 3;
      if (l > MAX_LINE) return MAX_LINE;
      return l;
   endfunction

   function automatic int unsigned clamp_cnt(input logic [CNT_BITS-1:0] c);
      return (c < 3) ? 3 : c;
   endfunction

   function automatic void restart_frame_model();
      col_m  = 0;
      row_m  = '0;
      left_m = 0;
   endfunction

   function automatic void predict_csr_write(input lss_csr_type idx,
                                             input logic [CSR_BITS-1:0] data);
      case (idx)
         CSR_LINE_LENGTH: line_length_m = data[LEN_BITS-1:0];
         CSR_LINE_COUNT:  line_count_m  = data[CNT_BITS-1:0];
      endcase
      restart_frame_model();
   endfunction

   function automatic void predict_sharpen(input logic kind, input logic [15:0] pix);
      int unsigned      len, cnt, p;
      int               up, centre, right, left, v;
      bit               border;
      sharp_result_type r;
      len = clamp_len(line_length_m);
      cnt = clamp_cnt(line_count_m);
      p   = col_m;
      if (p >= len) p = 0;
      // last line waiting: every item pushes one border pixel out
      if (row_m >= cnt) begin
         centre  = middle_line[p];
         v       = 2 * centre;
         r.value = v[RESULT_BITS-1:0];
         r.last  = (p == len - 1);
         sharpened_q.push_back(r);
         p++;
         if (p >= len) restart_frame_model();
         else col_m = p;
         return;
      end
      if (kind == KIND_DRAIN) return;
      up     = older_line[p];
      centre = middle_line[p];
      right  = 0;
      if (p + 1 < len) right = middle_line[p + 1];
      left   = left_m;
      older_line[p]  = centre[15:0];
      middle_line[p] = pix;
      left_m = centre;
      if (row_m >= 16'd1) begin
         border = (row_m == 16'd1) || (p == 0) || (p == len - 1);
         if (border) v = 2 * centre;
         else v = 6 * centre - (up + int'({16'd0, pix}) + left + right);
         r.value = v[RESULT_BITS-1:0];
         r.last  = 1'b0;
         sharpened_q.push_back(r);
      end
      p++;
      if (p >= len) begin
         p     = 0;
         row_m = row_m + 16'd1;
      end
      col_m = p;
   endfunction

   function automatic logic [15:0] rand_pixel();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // predict on accepted inputs, then check the accepted result
   always @(posedge clock) begin
      sharp_result_type want;
      if (reset) begin
         line_length_m = LEN_BITS'(LINE_LENGTH_RESET);
         line_count_m  = LINE_COUNT_RESET;
         restart_frame_model();
         sharpened_q.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready)
            predict_csr_write(lss_csr_type'(csr_bus.index), csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            predict_sharpen(req_bus.kind, req_bus.pixel);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (sharpened_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %0d last %0b", $time,
                        rsp_bus.sharpened_times_two, rsp_bus.last_of_frame);
               errors++;
            end else begin
               want = sharpened_q.pop_front();
               if (rsp_bus.sharpened_times_two !== want.value) begin
                  $display("%0t: sharpened_times_two mismatch: expected %0d, actual %0d",
                           $time, want.value, rsp_bus.sharpened_times_two);
                  errors++;
               end
               if (rsp_bus.last_of_frame !== want.last) begin
                  $display("%0t: last_of_frame mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_bus.last_of_frame);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: ready with random stalls and an occasional long hold
   initial begin : rsp_side
      int n;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_len != 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // returns at the accepting edge with valid still high
   task automatic send_item(input logic kind, input logic [PIXEL_BITS-1:0] pix);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.pixel <= pix;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_idle(input int tail);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sharpened_q.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // chain keeps valid high for a write that follows at once
   task automatic write_csr(input lss_csr_type idx, input logic [CSR_BITS-1:0] data,
                            input bit chain);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (!chain) csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_BITS-1:0] len_data,
                            input logic [CSR_BITS-1:0] cnt_data);
      wait_idle(4);
      write_csr(CSR_LINE_LENGTH, len_data, 1'b1);
      write_csr(CSR_LINE_COUNT, cnt_data, 1'b0);
   endtask

   task automatic test_directed_extremes();
      // length 1 and count 0 both clamp to 3; upper data bits are dropped
      configure(16'hE001, 16'h0000);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_item(KIND_DRAIN, 16'hFFFF);
      // black centre in a white cross: most negative result
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'hFFFF);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'hFFFF);
      send_item(KIND_DRAIN, 16'h5A5A);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'hFFFF);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'hFFFF);
      send_item(KIND_PIXEL, 16'h0000);
      // flush; a pixel here only pushes a result out
      send_item(KIND_DRAIN, 16'h0000);
      send_item(KIND_PIXEL, 16'h1234);
      send_item(KIND_DRAIN, 16'h0000);
      // white centre on black: most positive result
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'hFFFF);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_PIXEL, 16'h0000);
      send_item(KIND_DRAIN, 16'h0000);
      send_item(KIND_DRAIN, 16'hFFFF);
      send_item(KIND_DRAIN, 16'h0000);
   endtask

   task automatic test_restart_on_write();
      int k;
      configure(16'd5, 16'd4);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      for (k = 0; k < 7; k++) send_item(KIND_PIXEL, rand_pixel());
      wait_idle(4);
      // abandon the partial frame
      write_csr(CSR_LINE_COUNT, 16'd4, 1'b0);
      for (k = 0; k < 20; k++) send_item(KIND_PIXEL, rand_pixel());
      for (k = 0; k < 5; k++) send_item(KIND_DRAIN, rand_pixel());
   endtask

   task automatic test_wide_line();
      int k;
      // length clamps to MAX_LINE; the first line stays open, so nothing comes out
      configure(16'h1FFF, 16'hFFFF);
      gaps_on   = 1'b0;
      stalls_on = 1'b1;
      for (k = 0; k < 160; k++) send_item(KIND_PIXEL, rand_pixel());
   endtask

   task automatic test_backpressure();
      int k;
      configure(16'd8, 16'd6);
      gaps_on      = 1'b0;
      stalls_on    = 1'b0;
      rsp_hold_len = 400;
      for (k = 0; k < 24; k++) send_item(KIND_PIXEL, rand_pixel());
      // hold input until every pending result is out, then finish the frame
      wait_idle(0);
      for (k = 24; k < 48; k++) send_item(KIND_PIXEL, rand_pixel());
      for (k = 0; k < 8; k++) send_item(KIND_DRAIN, rand_pixel());
   endtask

   task automatic test_random_frames();
      int                  sent, pass_no, sel, ec_len, ec_cnt, n_px, k;
      logic [LEN_BITS-1:0] len_val, new_len;
      logic [CNT_BITS-1:0] cnt_val, new_cnt;
      bit                  broken;
      sent    = 0;
      pass_no = 0;
      len_val = '0;
      cnt_val = '0;
      while (sent < 830) begin
         wait_idle(4);
         gaps_on   = (sent < 650) && ($urandom_range(0, 3) != 0);
         stalls_on = (sent < 650) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       new_len = LEN_BITS'($urandom_range(0, 2));
            1:       new_len = LEN_BITS'($urandom_range(13, 40));
            default: new_len = LEN_BITS'($urandom_range(3, 12));
         endcase
         if ($urandom_range(0, 11) == 0) new_cnt = 16'hFFFF;
         else new_cnt = CNT_BITS'($urandom_range(0, 7));
         // write one or both registers; any write restarts the frame
         sel = (pass_no == 0) ? 0 : $urandom_range(0, 3);
         if (sel != 2) begin
            write_csr(CSR_LINE_LENGTH, {3'($urandom), new_len}, sel != 1);
            len_val = new_len;
         end
         if (sel != 1) begin
            write_csr(CSR_LINE_COUNT, new_cnt, 1'b0);
            cnt_val = new_cnt;
         end
         ec_len = clamp_len(len_val);
         ec_cnt = clamp_cnt(cnt_val);
         broken = (ec_cnt > 8) || ($urandom_range(0, 4) == 0);
         if (broken) begin
            n_px = $urandom_range(1, ec_len * ((ec_cnt > 8) ? 4 : ec_cnt + 1) - 1);
            for (k = 0; k < n_px; k++)
               send_item(($urandom_range(0, 3) == 0) ? KIND_DRAIN : KIND_PIXEL, rand_pixel());
            sent += n_px;
         end else begin
            for (k = 0; k < ec_len * ec_cnt; k++) begin
               if ($urandom_range(0, 29) == 0) send_item(KIND_DRAIN, rand_pixel());
               send_item(KIND_PIXEL, rand_pixel());
            end
            for (k = 0; k < ec_len; k++)
               send_item(($urandom_range(0, 5) == 0) ? KIND_PIXEL : KIND_DRAIN, rand_pixel());
            sent += ec_len * (ec_cnt + 1);
         end
         pass_no++;
      end
   endtask

   initial begin
      int k;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.kind  <= KIND_PIXEL;
      req_bus.pixel <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_LINE_LENGTH;
      csr_bus.data  <= '0;
      for (k = 0; k < MAX_LINE; k++) begin
         older_line[k]  = '0;
         middle_line[k] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_restart_on_write();
      test_wide_line();
      test_backpressure();
      test_random_frames();

      wait_idle(8);
      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
